### rtl/core/scr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scr_pkg;

    // Fixed field widths
    localparam int ROW_W    = 7;
    localparam int COL_W    = 7;
    localparam int DIM_W    = 8;
    localparam int NEW_W    = 15;
    localparam int CNT_W    = 15;
    localparam int AREA_W   = 15;
    localparam int CTR_W    = 13;
    localparam int PROD_W   = 16;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 15;
    localparam int OUT_W    = 32;

    // Request kinds carried in tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Register indexes
    localparam logic [CFG_IX_W-1:0] REG_MAP_COLS    = 2'd0;
    localparam logic [CFG_IX_W-1:0] REG_MAP_ROWS    = 2'd1;
    localparam logic [CFG_IX_W-1:0] REG_MIN_AREA    = 2'd2;
    localparam logic [CFG_IX_W-1:0] REG_NUM_CENTERS = 2'd3;

    // Neighbor scan order
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic             func;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } req_t;

    typedef struct packed {
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  cols;
        logic [AREA_W-1:0] min_area;
        logic [CTR_W-1:0]  num_centers;
    } pass_cfg_t;

    // Clamp a map dimension into 1..hi
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > hi)
            r = DIM_W'(hi);
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/scr_area_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module scr_area_div
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire [scr_pkg::PROD_W-1:0]  dividend,
    input  wire [scr_pkg::CTR_W-1:0]   divisor,
    output logic                       busy,
    output logic [scr_pkg::PROD_W-1:0] quotient
);
    import scr_pkg::*;

    localparam int CNT_BITS = $clog2(PROD_W + 1);

    logic [CTR_W-1:0]      rem_reg;
    logic [CTR_W-1:0]      rem_next;
    logic [PROD_W-1:0]     quo_reg;
    logic [PROD_W-1:0]     quo_next;
    logic [CTR_W-1:0]      dsr_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic [CTR_W:0]        trial;

    // One restoring step; the remainder always stays below the divisor
    always_comb
    begin
        trial = {rem_reg, quo_reg[PROD_W-1]};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = CTR_W'(trial - {1'b0, dsr_reg});
            quo_next = {quo_reg[PROD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[CTR_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(PROD_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/core/scr_relabel_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Label stores, flood list and the relabel sequencer
module scr_relabel_core
#(
    parameter int MAX_COLS   = 128,
    parameter int MAX_ROWS   = 128,
    parameter int LABEL_BITS = 13
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  scr_pkg::pass_cfg_t         cfg,
    input  wire                        cfg_write,
    input  wire                        req_valid,
    input  scr_pkg::req_t              req,
    input  wire [LABEL_BITS-1:0]       req_label,
    output logic                       req_ready,
    output logic                       resp_valid,
    input  wire                        resp_ready,
    output logic [scr_pkg::NEW_W-1:0]  resp_label,
    output logic [scr_pkg::CNT_W-1:0]  resp_count
);
    import scr_pkg::*;

    localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RB + CB;
    localparam int DEPTH = 1 << AW;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int FW    = AW + 1;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_PSTART = 5'd1;
    localparam logic [4:0] S_CLR    = 5'd2;
    localparam logic [4:0] S_WDIV   = 5'd3;
    localparam logic [4:0] S_SEED   = 5'd4;
    localparam logic [4:0] S_SEEDW  = 5'd5;
    localparam logic [4:0] S_ADJ    = 5'd6;
    localparam logic [4:0] S_ADJW   = 5'd7;
    localparam logic [4:0] S_FRD    = 5'd8;
    localparam logic [4:0] S_FRDW   = 5'd9;
    localparam logic [4:0] S_FNB    = 5'd10;
    localparam logic [4:0] S_FNBW   = 5'd11;
    localparam logic [4:0] S_SEGEND = 5'd12;
    localparam logic [4:0] S_MRD    = 5'd13;
    localparam logic [4:0] S_MRDW   = 5'd14;
    localparam logic [4:0] S_NEXT   = 5'd15;
    localparam logic [4:0] S_RD     = 5'd16;
    localparam logic [4:0] S_RDW    = 5'd17;
    localparam logic [4:0] S_RESP   = 5'd18;

    localparam logic [NEW_W-1:0]      NO_LABEL = '1;
    localparam logic [LABEL_BITS-1:0] NO_DATA  = '1;

    // Memories
    logic [LABEL_BITS-1:0] orig_mem  [DEPTH];
    logic [NEW_W-1:0]      new_mem   [DEPTH];
    logic [AW-1:0]         flood_mem [DEPTH];

    logic [LABEL_BITS-1:0] orig_rd;
    logic [NEW_W-1:0]      new_rd;
    logic [AW-1:0]         flood_rd;

    logic                  orig_we;
    logic [AW-1:0]         orig_wa;
    logic [AW-1:0]         orig_ra;
    logic                  new_we;
    logic [AW-1:0]         new_wa;
    logic [NEW_W-1:0]      new_wd;
    logic [AW-1:0]         new_ra;
    logic                  flood_we;
    logic [AW-1:0]         flood_wa;
    logic [AW-1:0]         flood_wd;
    logic [AW-1:0]         flood_ra;

    // Control state
    logic [4:0]            state_reg;
    logic                  pass_done_reg;
    logic [NEW_W-1:0]      next_label_reg;
    logic [NEW_W-1:0]      label_reg;
    logic [RB-1:0]         r_reg;
    logic [CB-1:0]         c_reg;
    logic [1:0]            k_reg;
    logic [FW-1:0]         e_reg;
    logic [FW-1:0]         count_reg;
    logic [LABEL_BITS-1:0] own_reg;
    logic [NEW_W-1:0]      adj_reg;
    logic [AW-1:0]         p_reg;
    logic [AW-1:0]         clr_reg;
    logic [AREA_W-1:0]     area_reg;
    logic [AW-1:0]         ra_reg;
    logic                  inmap_reg;
    logic [NEW_W-1:0]      res_reg;

    // Divider for the automatic area
    logic                  div_start;
    logic                  div_busy;
    logic [PROD_W-1:0]     div_q;
    logic [PROD_W-1:0]     map_cells;

    assign map_cells = PROD_W'(cfg.rows) * PROD_W'(cfg.cols);
    assign div_start = (state_reg == S_PSTART) && (cfg.num_centers != '0);

    scr_area_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (map_cells),
        .divisor  (cfg.num_centers),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Neighbor address of the seed or of the current flood entry
    logic [RB-1:0] base_row;
    logic [CB-1:0] base_col;
    logic          nb_valid;
    logic [AW-1:0] nb_addr;
    logic [AW-1:0] seed_addr;
    logic [AW-1:0] req_addr;
    logic          req_in_store;
    logic          req_in_map;
    logic          grow;
    logic          k_last;

    assign seed_addr = {r_reg, c_reg};
    assign k_last    = (k_reg == DIR_RIGHT);

    always_comb
    begin
        if (state_reg == S_ADJ || state_reg == S_ADJW)
        begin
            base_row = r_reg;
            base_col = c_reg;
        end
        else
        begin
            base_row = p_reg[AW-1:CB];
            base_col = p_reg[CB-1:0];
        end
        nb_valid = 1'b0;
        nb_addr  = {base_row, base_col};
        case (k_reg)
            DIR_UP:
            begin
                nb_valid = (base_row != '0);
                nb_addr  = {base_row - 1'b1, base_col};
            end
            DIR_LEFT:
            begin
                nb_valid = (base_col != '0);
                nb_addr  = {base_row, base_col - 1'b1};
            end
            DIR_DOWN:
            begin
                nb_valid = (32'(base_row) + 1 < 32'(cfg.rows));
                nb_addr  = {base_row + 1'b1, base_col};
            end
            DIR_RIGHT:
            begin
                nb_valid = (32'(base_col) + 1 < 32'(cfg.cols));
                nb_addr  = {base_row, base_col + 1'b1};
            end
            default:
            begin
                nb_valid = 1'b0;
            end
        endcase
    end

    assign req_addr     = {RB'(req.row), CB'(req.col)};
    assign req_in_store = (32'(req.row) < MAX_ROWS) && (32'(req.col) < MAX_COLS);
    assign req_in_map   = (32'(req.row) < 32'(cfg.rows)) && (32'(req.col) < 32'(cfg.cols));
    assign grow         = (new_rd == NO_LABEL) && (orig_rd == own_reg) &&
                          (32'(count_reg) < CELLS);

    // Memory port selection
    always_comb
    begin
        orig_we  = 1'b0;
        orig_wa  = req_addr;
        orig_ra  = seed_addr;
        new_we   = 1'b0;
        new_wa   = seed_addr;
        new_wd   = label_reg;
        new_ra   = seed_addr;
        flood_we = 1'b0;
        flood_wa = count_reg[AW-1:0];
        flood_wd = nb_addr;
        flood_ra = e_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                orig_we = req_valid && (req.func == FUNC_WRITE) && req_in_store;
            end
            S_CLR:
            begin
                new_we = 1'b1;
                new_wa = clr_reg;
                new_wd = NO_LABEL;
            end
            S_SEEDW:
            begin
                if (new_rd == NO_LABEL && orig_rd != NO_DATA)
                begin
                    new_we   = 1'b1;
                    flood_we = 1'b1;
                    flood_wa = '0;
                    flood_wd = seed_addr;
                end
            end
            S_ADJ:
            begin
                new_ra = nb_addr;
            end
            S_FNB:
            begin
                new_ra  = nb_addr;
                orig_ra = nb_addr;
            end
            S_FNBW:
            begin
                if (grow)
                begin
                    new_we   = 1'b1;
                    new_wa   = nb_addr;
                    flood_we = 1'b1;
                end
            end
            S_MRDW:
            begin
                new_we = 1'b1;
                new_wa = flood_rd;
                new_wd = adj_reg;
            end
            S_RD:
            begin
                orig_ra = ra_reg;
                new_ra  = ra_reg;
            end
            default:
            begin
                orig_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (orig_we)
            orig_mem[orig_wa] <= req_label;
        orig_rd <= orig_mem[orig_ra];
    end

    always_ff @(posedge clk)
    begin
        if (new_we)
            new_mem[new_wa] <= new_wd;
        new_rd <= new_mem[new_ra];
    end

    always_ff @(posedge clk)
    begin
        if (flood_we)
            flood_mem[flood_wa] <= flood_wd;
        flood_rd <= flood_mem[flood_ra];
    end

    // Read result: all ones outside the map, else the original label sign-extended when relabeling is off
    logic signed [31:0] orig_ext;
    logic [NEW_W-1:0]   rd_value;

    always_comb
    begin
        orig_ext = 32'(signed'(orig_rd));
        if (!inmap_reg)
            rd_value = NO_LABEL;
        else if (cfg.num_centers == '0)
            rd_value = orig_ext[NEW_W-1:0];
        else
            rd_value = new_rd;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pass_done_reg  <= 1'b0;
            next_label_reg <= '0;
            label_reg      <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            k_reg          <= '0;
            e_reg          <= '0;
            count_reg      <= '0;
            clr_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
                pass_done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req.func == FUNC_WRITE)
                        begin
                            if (req_in_store)
                                pass_done_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= pass_done_reg ? S_RD : S_PSTART;
                        end
                    end
                end
                S_PSTART:
                begin
                    next_label_reg <= '0;
                    pass_done_reg  <= 1'b1;
                    label_reg      <= '0;
                    clr_reg        <= '0;
                    state_reg      <= (cfg.num_centers == '0) ? S_RD : S_CLR;
                end
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= S_WDIV;
                end
                S_WDIV:
                begin
                    if (!div_busy)
                    begin
                        r_reg     <= '0;
                        c_reg     <= '0;
                        state_reg <= S_SEED;
                    end
                end
                S_SEED:
                begin
                    state_reg <= S_SEEDW;
                end
                S_SEEDW:
                begin
                    if (new_rd != NO_LABEL || orig_rd == NO_DATA)
                        state_reg <= S_NEXT;
                    else
                    begin
                        count_reg <= FW'(1);
                        k_reg     <= DIR_UP;
                        state_reg <= S_ADJ;
                    end
                end
                S_ADJ, S_ADJW:
                begin
                    if (state_reg == S_ADJ && nb_valid)
                        state_reg <= S_ADJW;
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (k_last)
                        begin
                            e_reg     <= '0;
                            state_reg <= S_FRD;
                        end
                        else
                            state_reg <= S_ADJ;
                    end
                end
                S_FRD:
                begin
                    state_reg <= (e_reg == count_reg) ? S_SEGEND : S_FRDW;
                end
                S_FRDW:
                begin
                    k_reg     <= DIR_UP;
                    state_reg <= S_FNB;
                end
                S_FNB, S_FNBW:
                begin
                    if (state_reg == S_FNB && nb_valid)
                        state_reg <= S_FNBW;
                    else
                    begin
                        if (state_reg == S_FNBW && grow)
                            count_reg <= count_reg + 1'b1;
                        k_reg <= k_reg + 1'b1;
                        if (k_last)
                        begin
                            e_reg     <= e_reg + 1'b1;
                            state_reg <= S_FRD;
                        end
                        else
                            state_reg <= S_FNB;
                    end
                end
                S_SEGEND:
                begin
                    if (32'(count_reg) <= 32'(area_reg) && adj_reg != NO_LABEL)
                    begin
                        e_reg     <= '0;
                        state_reg <= S_MRD;
                    end
                    else
                    begin
                        label_reg <= label_reg + 1'b1;
                        state_reg <= S_NEXT;
                    end
                end
                S_MRD:
                begin
                    state_reg <= (e_reg == count_reg) ? S_NEXT : S_MRDW;
                end
                S_MRDW:
                begin
                    e_reg     <= e_reg + 1'b1;
                    state_reg <= S_MRD;
                end
                S_NEXT:
                begin
                    if (32'(c_reg) + 1 >= 32'(cfg.cols))
                    begin
                        c_reg <= '0;
                        if (32'(r_reg) + 1 >= 32'(cfg.rows))
                        begin
                            next_label_reg <= label_reg;
                            state_reg      <= S_RD;
                        end
                        else
                        begin
                            r_reg     <= r_reg + 1'b1;
                            state_reg <= S_SEED;
                        end
                    end
                    else
                    begin
                        c_reg     <= c_reg + 1'b1;
                        state_reg <= S_SEED;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_RDW;
                end
                S_RDW:
                begin
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (resp_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid && req.func == FUNC_READ)
        begin
            ra_reg    <= req_addr;
            inmap_reg <= req_in_map;
        end
        if (state_reg == S_WDIV)
            area_reg <= (cfg.min_area != '0) ? cfg.min_area : AREA_W'(div_q[PROD_W-1:2]);
        if (state_reg == S_SEEDW)
        begin
            own_reg <= orig_rd;
            adj_reg <= NO_LABEL;
        end
        if (state_reg == S_ADJW && !new_rd[NEW_W-1])
            adj_reg <= new_rd;
        if (state_reg == S_FRDW)
            p_reg <= flood_rd;
        if (state_reg == S_RDW)
            res_reg <= rd_value;
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign resp_valid = (state_reg == S_RESP);
    assign resp_label = res_reg;
    assign resp_count = next_label_reg;

endmodule

`default_nettype wire

### rtl/core/superpixel_connectivity_relabel.sv
`timescale 1ns / 1ps
`default_nettype none

// Superpixel connectivity relabel. Write words (tuser 0) load one original label into the
// map at row/col and are taken one per cycle while the block is idle. A read word (tuser 1)
// returns the relabelled entry and the number of segments issued. The first read after any
// map or register write runs a relabel pass if the number of centers is nonzero: a clearing
// sweep of all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) new label entries (16384 by default), then
// a raster scan that floods each segment, checks its neighbors and rewrites its members when
// it is small and merged. The pass is set by the single read port and single write port of
// each label memory. Results sit in an output register so new words are taken while one
// waits. Register writes are taken only while the block is idle and no input word is offered.
module superpixel_connectivity_relabel
#(
    parameter int MAX_COLS   = 128,
    parameter int MAX_ROWS   = 128,
    parameter int LABEL_BITS = 13
)
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration write channel
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [scr_pkg::CFG_IX_W-1:0]          cfg_addr,
    input  wire [scr_pkg::CFG_D_W-1:0]           cfg_data,
    // input words
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pixel_row, pixel_col, label_in, zero fill
    input  wire [((14+LABEL_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // func
    input  wire                                  s_axis_tuser,
    // result words
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // new_label, segment_count, zero fill
    output logic [scr_pkg::OUT_W-1:0]            m_axis_tdata
);
    import scr_pkg::*;

    localparam int LBL_LO = ROW_W + COL_W;

    // Configuration registers
    logic [DIM_W-1:0]  map_cols_reg;
    logic [DIM_W-1:0]  map_rows_reg;
    logic [AREA_W-1:0] min_area_reg;
    logic [CTR_W-1:0]  num_centers_reg;
    logic              cfg_write;
    logic              core_ready;

    // never in the same cycle as an input word
    assign cfg_ready = core_ready && !s_axis_tvalid;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_cols_reg    <= DIM_W'(128);
            map_rows_reg    <= DIM_W'(128);
            min_area_reg    <= '0;
            num_centers_reg <= CTR_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_MAP_COLS:    map_cols_reg    <= cfg_data[DIM_W-1:0];
                REG_MAP_ROWS:    map_rows_reg    <= cfg_data[DIM_W-1:0];
                REG_MIN_AREA:    min_area_reg    <= cfg_data[AREA_W-1:0];
                REG_NUM_CENTERS: num_centers_reg <= cfg_data[CTR_W-1:0];
                default:         map_cols_reg    <= map_cols_reg;
            endcase
        end
    end

    pass_cfg_t cfg;

    always_comb
    begin
        cfg.rows        = clamp_dim(map_rows_reg, MAX_ROWS);
        cfg.cols        = clamp_dim(map_cols_reg, MAX_COLS);
        cfg.min_area    = min_area_reg;
        cfg.num_centers = num_centers_reg;
    end

    // Unpack the input word
    req_t req;

    always_comb
    begin
        req.func = s_axis_tuser;
        req.row  = s_axis_tdata[ROW_W-1:0];
        req.col  = s_axis_tdata[LBL_LO-1:ROW_W];
    end

    logic              resp_valid;
    logic              resp_ready;
    logic [NEW_W-1:0]  resp_label;
    logic [CNT_W-1:0]  resp_count;

    scr_relabel_core
    #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .LABEL_BITS (LABEL_BITS)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_write  (cfg_write),
        .req_valid  (s_axis_tvalid),
        .req        (req),
        .req_label  (s_axis_tdata[LBL_LO+LABEL_BITS-1:LBL_LO]),
        .req_ready  (core_ready),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp_label (resp_label),
        .resp_count (resp_count)
    );

    assign s_axis_tready = core_ready;

    // Output register
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;

    assign resp_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (resp_ready)
            m_valid_reg <= resp_valid;
    end

    always_ff @(posedge clk)
    begin
        if (resp_ready && resp_valid)
            m_data_reg <= {(OUT_W - NEW_W - CNT_W)'(0), resp_count, resp_label};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import scr_pkg::*;

    localparam int MAXC     = 128;
    localparam int MAXR     = 128;
    localparam int CELLS    = MAXC * MAXR;
    localparam int LIMIT    = 10000000;
    localparam int SETTLE   = 64;
    localparam int LONG_OFF = 24000;

    typedef struct {
        logic               func;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic signed [12:0] label;
    } pix_word_t;

    typedef struct {
        logic [NEW_W-1:0] new_label;
        logic [CNT_W-1:0] seg_count;
    } relabel_res_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IX_W-1:0]          cfg_addr;
    logic [CFG_D_W-1:0]           cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [31:0]                  s_axis_tdata;
    logic                         s_axis_tuser;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [OUT_W-1:0]             m_axis_tdata;

    superpixel_connectivity_relabel uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state
    int  pm_cols, pm_rows, pm_area, pm_ctrs;
    int  orig_map [CELLS];
    int  seg_map [CELLS];
    int  flood_q [CELLS];
    int  issued;
    bit  relabel_valid;

    // Stimulus side shadow of the map
    int  gen_map [CELLS];
    bit  gen_written [CELLS];

    pix_word_t    pend_q [$];
    relabel_res_t expect_q [$];
    int errors, words_in, results_out, phases, cyc;
    int hold_req, hold_seen;

    function automatic int clampd(int v);
        return (v < 1) ? 1 : ((v > 128) ? 128 : v);
    endfunction

    // Raster scan with 4-connected flood fill, small segments merged
    function void relabel_map();
        int rows, cols, lbl, area, seed, own, adj, count, pr, pc, nr, nc, n;
        rows = clampd(pm_rows);
        cols = clampd(pm_cols);
        lbl = 0;
        area = pm_area;
        issued = 0;
        relabel_valid = 1'b1;
        if (pm_ctrs == 0)
            return;
        if (area == 0)
            area = ((rows * cols) / pm_ctrs) >> 2;
        for (int i = 0; i < CELLS; i++)
            seg_map[i] = -1;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                seed = r * MAXC + c;
                if (seg_map[seed] != -1 || orig_map[seed] == -1)
                    continue;
                own = orig_map[seed];
                adj = -1;
                count = 1;
                seg_map[seed] = lbl;
                flood_q[0] = seed;
                // last labelled neighbor in up, left, down, right order
                for (int k = 0; k < 4; k++)
                begin
                    nr = r + ((k == 0) ? -1 : (k == 2) ? 1 : 0);
                    nc = c + ((k == 1) ? -1 : (k == 3) ? 1 : 0);
                    if (nr >= 0 && nr < rows && nc >= 0 && nc < cols &&
                        seg_map[nr * MAXC + nc] >= 0)
                        adj = seg_map[nr * MAXC + nc];
                end
                for (int e = 0; e < count; e++)
                begin
                    pr = flood_q[e] / MAXC;
                    pc = flood_q[e] % MAXC;
                    for (int k = 0; k < 4; k++)
                    begin
                        nr = pr + ((k == 0) ? -1 : (k == 2) ? 1 : 0);
                        nc = pc + ((k == 1) ? -1 : (k == 3) ? 1 : 0);
                        if (nr < 0 || nr >= rows || nc < 0 || nc >= cols)
                            continue;
                        n = nr * MAXC + nc;
                        if (seg_map[n] == -1 && orig_map[n] == own && count < CELLS)
                        begin
                            flood_q[count] = n;
                            count++;
                            seg_map[n] = lbl;
                        end
                    end
                end
                if (count <= area && adj != -1)
                begin
                    for (int e = 0; e < count; e++)
                        seg_map[flood_q[e]] = adj;
                end
                else
                    lbl++;
            end
        end
        issued = lbl;
    endfunction

    // Apply one accepted word to the predictor
    function void predict_word(pix_word_t w);
        int v;
        relabel_res_t res;
        if (w.func == FUNC_WRITE)
        begin
            orig_map[w.row * MAXC + w.col] = w.label;
            relabel_valid = 1'b0;
        end
        else
        begin
            if (!relabel_valid)
                relabel_map();
            v = -1;
            if (w.row < clampd(pm_rows) && w.col < clampd(pm_cols))
                v = (pm_ctrs == 0) ? orig_map[w.row * MAXC + w.col]
                                   : seg_map[w.row * MAXC + w.col];
            res.new_label = NEW_W'(v);
            res.seg_count = CNT_W'(issued);
            expect_q.insert(expect_q.size(), res);
        end
    endfunction

    // Word driver: bursts of random length with random gaps
    pix_word_t cur_word;
    int burst_left, gap_left;
    always @(posedge clk)
    begin
        logic nv;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_word(cur_word);
                words_in++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                nv = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pend_q.size() > 0)
                begin
                    cur_word = pend_q.pop_front();
                    s_axis_tdata <= {5'd0, cur_word.label, cur_word.col, cur_word.row};
                    s_axis_tuser <= cur_word.func;
                    nv = 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        if ($urandom_range(0, 9) < 3)
                            gap_left = $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                s_axis_tvalid <= nv;
            end
        end
    end

    // Result receiver: changing stall pattern, plus an occasional long hold-off
    int rx_mode, rx_tick, hold_left;
    always @(posedge clk)
    begin
        logic rdy;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_mode = 0;
            rx_tick = 0;
            hold_left = 0;
        end
        else
        begin
            rx_tick++;
            if (rx_tick % 256 == 0)
                rx_mode = $urandom_range(0, 2);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = LONG_OFF;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: rdy = 1'b1;
                    1: rdy = (rx_tick % 3 == 0);
                    default: rdy = 1'($urandom_range(0, 1));
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        relabel_res_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_out++;
            if (expect_q.size() == 0)
            begin
                $error("unexpected result word %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                e = expect_q.pop_front();
                if (m_axis_tdata[NEW_W-1:0] !== e.new_label)
                begin
                    $error("new_label exp %0d got %0d", $signed(e.new_label),
                           $signed(m_axis_tdata[NEW_W-1:0]));
                    errors++;
                end
                if (m_axis_tdata[NEW_W+CNT_W-1:NEW_W] !== e.seg_count)
                begin
                    $error("segment_count exp %0d got %0d", e.seg_count,
                           m_axis_tdata[NEW_W+CNT_W-1:NEW_W]);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cyc++;
        if (cyc > LIMIT)
        begin
            $display("timeout after %0d cycles", cyc);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic drain();
        do
            @(posedge clk);
        while (!(pend_q.size() == 0 && !s_axis_tvalid && expect_q.size() == 0));
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IX_W-1:0] ix, int val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= ix;
        cfg_data  <= CFG_D_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (ix)
            REG_MAP_COLS:    pm_cols = val & 'hFF;
            REG_MAP_ROWS:    pm_rows = val & 'hFF;
            REG_MIN_AREA:    pm_area = val & 'h7FFF;
            REG_NUM_CENTERS: pm_ctrs = val & 'h1FFF;
            default: ;
        endcase
        relabel_valid = 1'b0;
    endtask

    task automatic push_word(logic f, int r, int c, int lbl);
        pix_word_t w;
        w.func = f;
        w.row = ROW_W'(r);
        w.col = COL_W'(c);
        w.label = 13'(lbl);
        if (f == FUNC_WRITE)
        begin
            gen_map[r * MAXC + c] = lbl;
            gen_written[r * MAXC + c] = 1'b1;
        end
        pend_q.insert(pend_q.size(), w);
    endtask

    // One phase: idle, set all registers, load the map, then read it back
    task automatic run_phase(int cols_d, int rows_d, int area_d, int ctrs_d,
                             int nreads, bit rewrite, int mids, bit long_hold);
        int c, r, idx, lbl, npal;
        int pal [6];
        drain();
        write_reg(REG_MAP_COLS, cols_d);
        write_reg(REG_MAP_ROWS, rows_d);
        write_reg(REG_MIN_AREA, area_d);
        write_reg(REG_NUM_CENTERS, ctrs_d);
        phases++;
        c = clampd(cols_d & 'hFF);
        r = clampd(rows_d & 'hFF);
        npal = $urandom_range(1, 6);
        for (int i = 0; i < 6; i++)
        begin
            case ($urandom_range(0, 9))
                0: pal[i] = 4095;
                1: pal[i] = -2 - $urandom_range(0, 4094);
                default: pal[i] = $urandom_range(0, 15);
            endcase
        end
        // blocky map so segments of many sizes appear
        for (int y = 0; y < r; y++)
        begin
            for (int x = 0; x < c; x++)
            begin
                idx = y * MAXC + x;
                if (!rewrite && gen_written[idx])
                    continue;
                if ($urandom_range(0, 99) < 65 && (x > 0 || y > 0))
                begin
                    if (y == 0 || (x > 0 && $urandom_range(0, 1)))
                        lbl = gen_map[idx - 1];
                    else
                        lbl = gen_map[idx - MAXC];
                end
                else if ($urandom_range(0, 9) == 0)
                    lbl = -1;
                else
                    lbl = pal[$urandom_range(0, npal - 1)];
                push_word(FUNC_WRITE, y, x, lbl);
            end
        end
        // writes anywhere in the store, also outside the map
        repeat ($urandom_range(0, 4))
            push_word(FUNC_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 8191));
        if (long_hold)
            hold_req++;
        for (int i = 0; i < nreads; i++)
        begin
            if (mids > 0 && i == nreads / 2)
            begin
                repeat (mids)
                    push_word(FUNC_WRITE, $urandom_range(0, r - 1), $urandom_range(0, c - 1),
                              pal[$urandom_range(0, npal - 1)]);
            end
            if ($urandom_range(0, 99) < 85)
                push_word(FUNC_READ, $urandom_range(0, r - 1), $urandom_range(0, c - 1),
                          $urandom_range(0, 8191));
            else
                push_word(FUNC_READ, $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 8191));
        end
    endtask

    initial
    begin
        int dvals [12];
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_addr <= '0;
        cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        m_axis_tready <= 1'b0;
        pm_cols = 128;
        pm_rows = 128;
        pm_area = 0;
        pm_ctrs = 1;
        issued = 0;
        relabel_valid = 1'b0;
        hold_req = 0;
        hold_seen = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: 4x3 map with no-data, extreme and odd negative labels
        dvals = '{5, 5, -1, 4095, 5, -2, -2, 4095, -4096, -1, 7, 7};
        write_reg(REG_MAP_COLS, 4);
        write_reg(REG_MAP_ROWS, 3);
        write_reg(REG_MIN_AREA, 2);
        write_reg(REG_NUM_CENTERS, 1);
        for (int i = 0; i < 12; i++)
            push_word(FUNC_WRITE, i / 4, i % 4, dvals[i]);
        for (int i = 0; i < 12; i++)
            push_word(FUNC_READ, i / 4, i % 4, 0);
        push_word(FUNC_READ, 127, 127, 0);
        push_word(FUNC_READ, 2, 4, 0);

        // extremes of the registers
        run_phase(256, 2, 0, 4096, 20, 1'b1, 0, 1'b0);
        run_phase(128, 1, 16384, 1, 20, 1'b1, 0, 1'b0);
        run_phase(1, 255, 3, 2, 20, 1'b1, 0, 1'b0);
        run_phase(6, 5, 1, 0, 20, 1'b1, 0, 1'b0);
        run_phase(6, 5, 0, 3, 60, 1'b0, 2, 1'b1);
        run_phase(128, 2, 0, 1, 30, 1'b1, 0, 1'b0);
        // random small maps
        for (int p = 0; p < 4; p++)
            run_phase($urandom_range(1, 16), $urandom_range(1, 16),
                      ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8),
                      ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4096),
                      $urandom_range(15, 40), $urandom_range(0, 3) != 0,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0, 1'b0);
        drain();

        $display("%0d words in, %0d results checked over %0d register settings",
                 words_in, results_out, phases + 1);
        $display("maps up to 128 columns or 128 rows, auto and explicit merge areas, zero centers");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
